@@ rtl/core/i2c_trs_pkg.sv @@
// Shared types and constants for the I2C target register space.
// No dependencies; imported by the top level and the register file.
`default_nettype none

package i2c_trs_pkg;

    typedef logic [7:0] byte_t;

    typedef enum logic [1:0] {
        REQ_LINE    = 2'd0,
        REQ_HOST_WR = 2'd1,
        REQ_HOST_RD = 2'd2
    } req_t;

    typedef struct packed {
        logic  en;
        byte_t addr;
        byte_t data;
    } wr_t;

    typedef struct packed {
        logic  en;
        byte_t addr;
    } rd_t;

    localparam int IN_W    = 24;
    localparam int USER_W  = 2;
    localparam int OUT_W   = 32;
    localparam int ADDR_W  = 7;

    localparam logic [ADDR_W-1:0] OWN_ADDR_RST = 7'h32;
    localparam logic [3:0]        BIT_BYTE     = 4'd8;
    localparam logic [3:0]        BIT_LAST     = 4'd9;

endpackage

`default_nettype wire

@@ rtl/core/i2c_trs_regfile.sv @@
// Byte register file: one write port, two registered read ports with write forwarding.
// Entries read as zero until written; indexes at or beyond FILE_DEPTH read zero.
// Depends on i2c_trs_pkg.
`default_nettype none

module i2c_trs_regfile #(
    parameter int FILE_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  i2c_trs_pkg::wr_t    wr,
    input  i2c_trs_pkg::rd_t    rd_a,
    input  i2c_trs_pkg::rd_t    rd_b,
    output i2c_trs_pkg::byte_t  rd_a_data,
    output i2c_trs_pkg::byte_t  rd_b_data
);
    import i2c_trs_pkg::*;

    localparam int AW = $clog2(FILE_DEPTH);

    byte_t                 mem_reg [FILE_DEPTH];
    logic [FILE_DEPTH-1:0] vld_reg;

    byte_t a_q_reg, a_fwd_reg, b_q_reg, b_fwd_reg;
    logic  a_vld_reg, a_ok_reg, a_hit_reg;
    logic  b_vld_reg, b_ok_reg, b_hit_reg;

    logic wr_ok, a_ok, b_ok, a_hit, b_hit;

    assign wr_ok = {1'b0, wr.addr}   < 9'(FILE_DEPTH);
    assign a_ok  = {1'b0, rd_a.addr} < 9'(FILE_DEPTH);
    assign b_ok  = {1'b0, rd_b.addr} < 9'(FILE_DEPTH);
    assign a_hit = wr.en && wr_ok && (wr.addr == rd_a.addr);
    assign b_hit = wr.en && wr_ok && (wr.addr == rd_b.addr);

    always_ff @(posedge clk)
    begin
        if (wr.en && wr_ok)
        begin
            mem_reg[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd_a.en)
        begin
            a_q_reg   <= mem_reg[rd_a.addr[AW-1:0]];
            a_fwd_reg <= wr.data;
        end
        if (rd_b.en)
        begin
            b_q_reg   <= mem_reg[rd_b.addr[AW-1:0]];
            b_fwd_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            a_vld_reg <= 1'b0;
            a_ok_reg  <= 1'b0;
            a_hit_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            b_ok_reg  <= 1'b0;
            b_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr.en && wr_ok)
            begin
                vld_reg[wr.addr[AW-1:0]] <= 1'b1;
            end
            if (rd_a.en)
            begin
                a_vld_reg <= vld_reg[rd_a.addr[AW-1:0]];
                a_ok_reg  <= a_ok;
                a_hit_reg <= a_hit;
            end
            if (rd_b.en)
            begin
                b_vld_reg <= vld_reg[rd_b.addr[AW-1:0]];
                b_ok_reg  <= b_ok;
                b_hit_reg <= b_hit;
            end
        end
    end

    assign rd_a_data = a_hit_reg ? a_fwd_reg : ((a_ok_reg && a_vld_reg) ? a_q_reg : '0);
    assign rd_b_data = b_hit_reg ? b_fwd_reg : ((b_ok_reg && b_vld_reg) ? b_q_reg : '0);

endmodule

`default_nettype wire

@@ rtl/core/i2c_target_register_space.sv @@
// I2C target serving a byte register file, driven by oversampled SCL/SDA beats.
// Depends on i2c_trs_pkg and i2c_trs_regfile.
//
//  port group   dir  width  contents
//  cfg_*        in   7      own bus address
//  s_t*         in   24+2   line sample or host access
//  m_t*         out  32     drive level, host read byte, bus write report
//
// One beat per cycle unless m_tready holds the result register; a result passes
// through the input register, then the result register, with the register file read in between.
// Prefetched read bytes land in the cycle after the prefetch and are folded into the
// send shift register on the following edge.
// Reset sets control state at once, not input data; file entries read zero until written.
// s_tready drops only while an item waits and the result register is held by m_tready.
`default_nettype none

module i2c_target_register_space #(
    parameter int FILE_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [i2c_trs_pkg::ADDR_W-1:0]      cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // scl_level, sda_level, host_index[7:0], host_value[7:0], zero fill
    input  logic [i2c_trs_pkg::IN_W-1:0]        s_tdata,
    // req_type[1:0]
    input  logic [i2c_trs_pkg::USER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sda_release, host_read_value[7:0], bus_write_seen, bus_write_index[7:0],
    // bus_write_value[7:0], zero fill
    output logic [i2c_trs_pkg::OUT_W-1:0]       m_tdata
);
    import i2c_trs_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_ACTIVE, PH_ACK} phase_t;
    typedef enum logic [1:0] {MODE_ADDR, MODE_PTR, MODE_WRITE, MODE_READ} mode_t;

    logic [ADDR_W-1:0] own_addr_reg;

    logic        in_v_reg;
    logic [1:0]  req_reg;
    logic        scl_reg, sda_reg;
    byte_t       hidx_reg, hval_reg;

    phase_t      ph_reg, ph_next;
    mode_t       md_reg, md_next;
    logic [3:0]  bc_reg, bc_next;
    byte_t       rs_reg, rs_next, ss_reg, ss_next, ptr_reg, ptr_next;
    logic        pscl_reg, pscl_next, psda_reg, psda_next, drv_reg, drv_next;
    logic        pend_reg;

    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    logic   adv, do_proc, accept;
    logic   pf_req, res_seen;
    byte_t  pf_addr, res_widx, res_wval, res_hrv, send_eff, rd_a_data, rd_b_data;
    wr_t    wr;
    rd_t    rd_a, rd_b;

    assign cfg_ready = 1'b1;
    assign adv       = !m_tvalid_reg || m_tready;
    assign do_proc   = in_v_reg && adv;
    assign s_tready  = !in_v_reg || adv;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign rd_a.en   = accept;
    assign rd_a.addr = s_tdata[9:2];
    assign rd_b.en   = do_proc && pf_req;
    assign rd_b.addr = pf_addr;
    assign send_eff  = pend_reg ? rd_b_data : ss_reg;

    i2c_trs_regfile #(
        .FILE_DEPTH (FILE_DEPTH)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .rd_a      (rd_a),
        .rd_b      (rd_b),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    always_comb
    begin
        ph_next   = ph_reg;
        md_next   = md_reg;
        bc_next   = bc_reg;
        rs_next   = rs_reg;
        ss_next   = send_eff;
        ptr_next  = ptr_reg;
        pscl_next = pscl_reg;
        psda_next = psda_reg;
        drv_next  = drv_reg;
        pf_req    = 1'b0;
        pf_addr   = ptr_reg;
        wr        = '0;
        res_seen  = 1'b0;
        res_widx  = '0;
        res_wval  = '0;
        res_hrv   = '0;

        case (req_reg)
            REQ_LINE:
            begin
                pscl_next = scl_reg;
                psda_next = sda_reg;
                if (ph_reg == PH_IDLE && !sda_reg && psda_reg)
                begin
                    ph_next = PH_ACTIVE;
                    bc_next = '0;
                    md_next = MODE_ADDR;
                end
                else
                begin
                    if (ph_reg == PH_ACTIVE && !pscl_reg && scl_reg)
                    begin
                        if (md_reg != MODE_READ)
                        begin
                            rs_next = {rs_reg[6:0], sda_reg};
                            bc_next = bc_reg + 4'd1;
                        end
                        if (bc_next == BIT_LAST)
                        begin
                            bc_next = '0;
                        end
                        if (bc_next == BIT_BYTE && md_reg != MODE_READ)
                        begin
                            unique case (md_reg)
                                MODE_ADDR:
                                begin
                                    if (rs_next[7:1] == own_addr_reg)
                                    begin
                                        ph_next = PH_ACK;
                                        if (rs_next[0])
                                        begin
                                            md_next  = MODE_READ;
                                            pf_req   = 1'b1;
                                            pf_addr  = ptr_reg;
                                            ptr_next = ptr_reg + 8'd1;
                                            bc_next  = '0;
                                        end
                                        else
                                        begin
                                            md_next = MODE_PTR;
                                        end
                                    end
                                    else
                                    begin
                                        ph_next = PH_IDLE;
                                    end
                                end
                                MODE_PTR:
                                begin
                                    ptr_next = rs_next;
                                    ph_next  = PH_ACK;
                                    md_next  = MODE_WRITE;
                                end
                                default:
                                begin
                                    wr       = '{en: 1'b1, addr: ptr_reg, data: rs_next};
                                    res_seen = {1'b0, ptr_reg} < 9'(FILE_DEPTH);
                                    if (res_seen)
                                    begin
                                        res_widx = ptr_reg;
                                        res_wval = rs_next;
                                    end
                                    ptr_next = ptr_reg + 8'd1;
                                    ph_next  = PH_ACK;
                                end
                            endcase
                        end
                    end

                    if (ph_next == PH_ACK && pscl_reg && !scl_reg)
                    begin
                        drv_next = 1'b0;
                        ph_next  = PH_ACTIVE;
                    end
                    else if (ph_next == PH_ACTIVE && pscl_reg && !scl_reg)
                    begin
                        drv_next = 1'b1;
                        if (md_next == MODE_READ)
                        begin
                            bc_next  = bc_next + 4'd1;
                            drv_next = (bc_next >= BIT_LAST) ? 1'b1 : send_eff[7];
                            ss_next  = {send_eff[6:0], 1'b0};
                            if (bc_next == BIT_LAST)
                            begin
                                bc_next  = '0;
                                pf_req   = 1'b1;
                                pf_addr  = ptr_next;
                                ptr_next = ptr_next + 8'd1;
                            end
                        end
                    end

                    // stop
                    if (scl_reg && sda_reg && !psda_reg)
                    begin
                        ph_next = PH_IDLE;
                        md_next = MODE_ADDR;
                        bc_next = '0;
                    end
                end
            end
            REQ_HOST_WR:
            begin
                wr = '{en: 1'b1, addr: hidx_reg, data: hval_reg};
            end
            REQ_HOST_RD:
            begin
                res_hrv = rd_a_data;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= s_tuser;
            scl_reg  <= s_tdata[0];
            sda_reg  <= s_tdata[1];
            hidx_reg <= s_tdata[9:2];
            hval_reg <= s_tdata[17:10];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg <= OWN_ADDR_RST;
            in_v_reg     <= 1'b0;
            ph_reg       <= PH_IDLE;
            md_reg       <= MODE_ADDR;
            bc_reg       <= '0;
            rs_reg       <= '0;
            ss_reg       <= '0;
            ptr_reg      <= '0;
            pscl_reg     <= 1'b1;
            psda_reg     <= 1'b1;
            drv_reg      <= 1'b1;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                own_addr_reg <= cfg_data;
            end

            if (accept)
            begin
                in_v_reg <= 1'b1;
            end
            else if (do_proc)
            begin
                in_v_reg <= 1'b0;
            end

            pend_reg <= do_proc && pf_req;

            if (do_proc)
            begin
                ph_reg       <= ph_next;
                md_reg       <= md_next;
                bc_reg       <= bc_next;
                rs_reg       <= rs_next;
                ss_reg       <= ss_next;
                ptr_reg      <= ptr_next;
                pscl_reg     <= pscl_next;
                psda_reg     <= psda_next;
                drv_reg      <= drv_next;
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {6'b0, res_wval, res_widx, res_seen, res_hrv, drv_next};
            end
            else
            begin
                ss_reg <= send_eff;
                if (m_tready)
                begin
                    m_tvalid_reg <= 1'b0;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_v_reg && m_tvalid_reg && !m_tready))
        else $error("input stalled without a held result");

    a_bus_write_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (do_proc && res_seen) |-> (md_reg == MODE_WRITE))
        else $error("bus write reported outside a write transfer");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(in_v_reg))
        else $error("result appeared without a pending item");

    a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_proc |=> (bc_reg <= BIT_LAST))
        else $error("bit counter out of range");
`endif

endmodule

`default_nettype wire

@@ bench/tb_i2c_target_register_space.sv @@
// Testbench for i2c_target_register_space: bit-banged bus transfers and host accesses.
// Predicts every output beat with a shadow of the target; needs i2c_trs_pkg and the RTL.
`default_nettype none

module tb_i2c_target_register_space;
    timeunit 1ns;
    timeprecision 1ps;

    import i2c_trs_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASES       = 6;
    localparam int PHASE_BEATS  = 285;

    typedef enum logic [1:0] {
        LINK_IDLE,
        LINK_ACTIVE,
        LINK_ACK
    } link_t;

    typedef enum logic [1:0] {
        XFER_ADDR,
        XFER_PTR,
        XFER_WRITE,
        XFER_READ
    } xfer_t;

    typedef struct packed {
        logic [5:0] fill;
        byte_t      wr_value;
        byte_t      wr_index;
        logic       wr_seen;
        byte_t      rd_value;
        logic       sda_rel;
    } result_t;

    class i2c_target_shadow;
        logic [ADDR_W-1:0] own_addr;
        link_t             link;
        xfer_t             xfer;
        logic [3:0]        bit_cnt;
        byte_t             rx_shift;
        byte_t             tx_shift;
        byte_t             reg_ptr;
        logic              prev_scl;
        logic              prev_sda;
        logic              drive;
        byte_t             regs [256];
        result_t           due [$];
        int                errors;
        int                checked;
        int                bus_stores;

        function new();
            own_addr   = OWN_ADDR_RST;
            link       = LINK_IDLE;
            xfer       = XFER_ADDR;
            bit_cnt    = '0;
            rx_shift   = '0;
            tx_shift   = '0;
            reg_ptr    = '0;
            prev_scl   = 1'b1;
            prev_sda   = 1'b1;
            drive      = 1'b1;
            errors     = 0;
            checked    = 0;
            bus_stores = 0;
            foreach (regs[i])
                regs[i] = '0;
        endfunction

        function void set_own_addr(logic [ADDR_W-1:0] a);
            own_addr = a;
        endfunction

        function void bus_sample(logic scl, logic sda, inout result_t r);
            logic pscl;
            logic psda;
            pscl     = prev_scl;
            psda     = prev_sda;
            prev_scl = scl;
            prev_sda = sda;

            if (link == LINK_IDLE && !sda && psda)
            begin
                link    = LINK_ACTIVE;
                bit_cnt = '0;
                xfer    = XFER_ADDR;
                return;
            end

            if (link == LINK_ACTIVE && !pscl && scl)
            begin
                if (xfer != XFER_READ)
                begin
                    rx_shift = {rx_shift[6:0], sda};
                    bit_cnt  = bit_cnt + 1'b1;
                end
                if (bit_cnt == BIT_LAST)
                    bit_cnt = '0;
                if (bit_cnt == BIT_BYTE && xfer != XFER_READ)
                begin
                    if (xfer == XFER_ADDR)
                    begin
                        if (rx_shift[7:1] == own_addr)
                        begin
                            link = LINK_ACK;
                            if (rx_shift[0])
                            begin
                                xfer     = XFER_READ;
                                tx_shift = regs[reg_ptr];
                                reg_ptr  = reg_ptr + 1'b1;
                                bit_cnt  = '0;
                            end
                            else
                                xfer = XFER_PTR;
                        end
                        else
                            link = LINK_IDLE;
                    end
                    else if (xfer == XFER_PTR)
                    begin
                        reg_ptr = rx_shift;
                        link    = LINK_ACK;
                        xfer    = XFER_WRITE;
                    end
                    else
                    begin
                        regs[reg_ptr] = rx_shift;
                        r.wr_seen     = 1'b1;
                        r.wr_index    = reg_ptr;
                        r.wr_value    = rx_shift;
                        reg_ptr       = reg_ptr + 1'b1;
                        link          = LINK_ACK;
                    end
                end
            end

            if (link == LINK_ACK && pscl && !scl)
            begin
                drive = 1'b0;
                link  = LINK_ACTIVE;
            end
            else if (link == LINK_ACTIVE && pscl && !scl)
            begin
                drive = 1'b1;
                if (xfer == XFER_READ)
                begin
                    bit_cnt  = bit_cnt + 1'b1;
                    drive    = (bit_cnt >= BIT_LAST) ? 1'b1 : tx_shift[7];
                    tx_shift = {tx_shift[6:0], 1'b0};
                    if (bit_cnt == BIT_LAST)
                    begin
                        bit_cnt  = '0;
                        tx_shift = regs[reg_ptr];
                        reg_ptr  = reg_ptr + 1'b1;
                    end
                end
            end

            // stop: data rises while clock is high
            if (scl && sda && !psda)
            begin
                link    = LINK_IDLE;
                xfer    = XFER_ADDR;
                bit_cnt = '0;
            end
        endfunction

        function void note_beat(req_t req, logic scl, logic sda, byte_t idx, byte_t val);
            result_t r;
            r = '0;
            case (req)
                REQ_LINE:    bus_sample(scl, sda, r);
                REQ_HOST_WR: regs[idx] = val;
                REQ_HOST_RD: r.rd_value = regs[idx];
                default:     ;
            endcase
            r.sda_rel = drive;
            if (r.wr_seen)
                bus_stores++;
            due.push_back(r);
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            result_t got;
            result_t want;
            got = data;
            checked++;
            if (due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat %h with nothing pending", data);
                return;
            end
            want = due.pop_front();
            if (got.sda_rel !== want.sda_rel || got.rd_value !== want.rd_value ||
                got.wr_seen !== want.wr_seen || got.wr_index !== want.wr_index ||
                got.wr_value !== want.wr_value || got.fill !== want.fill)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("result %0d: want rel=%b rd=%h seen=%b idx=%h val=%h fill=%h",
                             checked, want.sda_rel, want.rd_value, want.wr_seen,
                             want.wr_index, want.wr_value, want.fill);
                    $display("    got rel=%b rd=%h seen=%b idx=%h val=%h fill=%h",
                             got.sda_rel, got.rd_value, got.wr_seen, got.wr_index,
                             got.wr_value, got.fill);
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [ADDR_W-1:0]   cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic [USER_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;

    i2c_target_shadow    shadow;
    logic [ADDR_W-1:0]   own_now;
    bit                  calm;
    bit                  src_gaps;
    bit                  sink_stalls;
    int                  beats;
    int                  host_beats;
    int                  transfers;
    int                  cycles;

    i2c_target_register_space u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            shadow.check_result(m_tdata);
    end

    initial
    begin
        m_tready    = 1'b0;
        sink_stalls = 1'b1;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                sink_stalls = !sink_stalls;
            if (!calm && sink_stalls && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_beat(req_t req, logic scl, logic sda, byte_t idx, byte_t val);
        @(negedge clk);
        if (!calm && src_gaps && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {6'd0, val, idx, sda, scl};
        do @(posedge clk); while (!s_tready);
        shadow.note_beat(req, scl, sda, idx, val);
        beats++;
    endtask

    task automatic pins(logic scl, logic sda);
        send_beat(REQ_LINE, scl, sda, 8'($urandom), 8'($urandom));
    endtask

    task automatic host_access();
        byte_t idx;
        idx = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        host_beats++;
        if ($urandom_range(0, 1))
            send_beat(REQ_HOST_WR, 1'($urandom), 1'($urandom), idx, 8'($urandom));
        else
            send_beat(REQ_HOST_RD, 1'($urandom), 1'($urandom), idx, 8'($urandom));
    endtask

    task automatic bus_bit(logic b);
        if ($urandom_range(0, 39) == 0)
            host_access();
        pins(1'b0, b);
        pins(1'b1, b);
        if ($urandom_range(0, 3) == 0)
            pins(1'b1, b);
        pins(1'b0, b);
    endtask

    task automatic bus_byte(byte_t v, logic ack);
        for (int i = 7; i >= 0; i--)
            bus_bit(v[i]);
        bus_bit(ack);
    endtask

    task automatic bus_start();
        pins(1'b1, 1'b1);
        pins(1'b1, 1'b0);
    endtask

    task automatic bus_stop();
        pins(1'b0, 1'b0);
        pins(1'b1, 1'b0);
        pins(1'b1, 1'b1);
    endtask

    task automatic read_bytes(int n);
        repeat (n)
        begin
            repeat (8) bus_bit(1'b1);
            bus_bit(1'($urandom));
        end
    endtask

    task automatic bus_transfer();
        int                kind;
        logic [ADDR_W-1:0] addr;
        byte_t             ptr;
        kind     = $urandom_range(0, 19);
        src_gaps = ($urandom_range(0, 3) != 0);
        addr     = own_now;
        ptr      = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        if ($urandom_range(0, 9) == 0)
            ptr = 8'hfe;
        if (kind >= 17)
            addr = addr ^ 7'($urandom_range(1, 127));
        transfers++;
        bus_start();
        if (kind < 8)
        begin
            bus_byte({addr, 1'b0}, 1'b1);
            bus_byte(ptr, 1'b1);
            repeat ($urandom_range(0, 5)) bus_byte(8'($urandom), 1'b1);
        end
        else if (kind < 15)
        begin
            bus_byte({addr, 1'b1}, 1'b1);
            read_bytes($urandom_range(1, 4));
        end
        else if (kind == 15)
        begin
            // repeated start is not honored: its clock rise and the second address byte shift in as data
            bus_byte({addr, 1'b0}, 1'b1);
            bus_byte(ptr, 1'b1);
            pins(1'b0, 1'b1);
            bus_start();
            bus_byte({addr, 1'b1}, 1'b1);
            read_bytes(1);
        end
        else if (kind == 16)
        begin
            repeat ($urandom_range(4, 24)) pins(1'($urandom), 1'($urandom));
        end
        else
        begin
            bus_byte({addr, 1'($urandom)}, 1'b1);
            bus_byte(8'($urandom), 1'b1);
        end
        if ($urandom_range(0, 9) != 0)
            bus_stop();
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (shadow.due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_own_addr(logic [ADDR_W-1:0] a);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= a;
        do @(posedge clk); while (!cfg_ready);
        shadow.set_own_addr(a);
        own_now = a;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int               target;
        logic [ADDR_W-1:0] next_addr;
        shadow     = new();
        own_now    = OWN_ADDR_RST;
        calm       = 1'b0;
        src_gaps   = 1'b1;
        beats      = 0;
        host_beats = 0;
        transfers  = 0;
        cycles     = 0;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = REQ_LINE;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // host port extremes, then a few raw line patterns
        send_beat(REQ_HOST_WR, 1'b0, 1'b0, 8'h00, 8'hff);
        send_beat(REQ_HOST_WR, 1'b1, 1'b1, 8'hff, 8'h00);
        send_beat(REQ_HOST_WR, 1'b0, 1'b1, 8'h80, 8'h5a);
        send_beat(REQ_HOST_RD, 1'b1, 1'b0, 8'h00, 8'h00);
        send_beat(REQ_HOST_RD, 1'b0, 1'b0, 8'hff, 8'hff);
        send_beat(REQ_HOST_RD, 1'b1, 1'b1, 8'h80, 8'h00);
        send_beat(REQ_HOST_RD, 1'b0, 1'b0, 8'h7f, 8'h00);
        pins(1'b1, 1'b0);
        pins(1'b0, 1'b0);
        pins(1'b1, 1'b0);
        pins(1'b1, 1'b1);
        pins(1'b0, 1'b1);
        pins(1'b0, 1'b0);
        pins(1'b1, 1'b0);
        pins(1'b1, 1'b1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                case (ph)
                    1:       next_addr = '0;
                    2:       next_addr = '1;
                    5:       next_addr = OWN_ADDR_RST;
                    default: next_addr = 7'($urandom_range(1, 126));
                endcase
                write_own_addr(next_addr);
            end
            calm   = (ph == PHASES - 1);
            target = beats + PHASE_BEATS;
            while (beats < target)
            begin
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 4)) host_access();
                else
                    bus_transfer();
            end
        end
        drain();

        $display("%0d beats: %0d bus transfers, %0d host accesses, %0d bus stores seen",
                 beats, transfers, host_beats, shadow.bus_stores);
        $display("%0d result beats checked over %0d address settings, %0d mismatches",
                 shadow.checked, PHASES, shadow.errors);
        if (shadow.errors == 0 && shadow.due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/i2c_trs_pkg.sv
rtl/core/i2c_trs_regfile.sv
rtl/core/i2c_target_register_space.sv
bench/tb_i2c_target_register_space.sv
